// ===== rtl/smr_pkg.sv =====
`default_nettype none
package smr_pkg;

    // Flush causes as they appear on the output.
    localparam logic [1:0] CAUSE_CLOSE   = 2'd0;
    localparam logic [1:0] CAUSE_ALL     = 2'd1;
    localparam logic [1:0] CAUSE_LATER   = 2'd2;
    localparam logic [1:0] CAUSE_EXPIRED = 2'd3;

    // Input command codes.
    localparam logic CMD_SEGMENT = 1'b0;
    localparam logic CMD_TICK    = 1'b1;

    // Register addresses.
    localparam logic [1:0] REG_TTL_MS = 2'd0;

    localparam logic [31:0] TTL_RESET = 32'd30000;

    // One flush job handed from the front end to the streaming back end.
    typedef struct packed {
        logic [23:0] addr;
        logic [7:0]  entry;
        logic [4:0]  count;
        logic [1:0]  cause;
    } t_flush_job;

    // Item taken by the front end.
    typedef struct packed {
        logic        cmd;
        logic [23:0] addr;
        logic [3:0]  seg_index;
        logic        close_out;
        logic [63:0] data_low;
        logic [15:0] data_high;
        logic [31:0] time_ms;
    } t_in_item;

endpackage
`default_nettype wire

// ===== rtl/smr_ram.sv =====
`default_nettype none
module smr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Synchronous write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/smr_front.sv =====
`default_nettype none
module smr_front #(
    parameter int ENTRIES  = 16,
    parameter int SEGMENTS = 16,
    parameter int EW       = 4,
    parameter int SW       = 4
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire smr_pkg::t_in_item   i_item,
    input  wire logic [31:0]         i_ttl_ms,
    // Segment store write port.
    output logic                     o_st_we,
    output logic [EW+SW-1:0]         o_st_waddr,
    output logic [79:0]              o_st_wdata,
    // Flush job queue write side.
    output logic                     o_job_valid,
    input  wire logic                i_job_ready,
    output smr_pkg::t_flush_job      o_job,
    // Back end has streamed the last segment of an entry's run.
    input  wire logic                i_done,
    input  wire logic [EW-1:0]       i_done_entry
);
    import smr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_EVAL  = 3'b010,
        S_FLUSH = 3'b100
    } t_state;

    t_state            r_state, n_state;
    t_in_item          r_item;
    logic [ENTRIES-1:0] r_valid;
    logic [ENTRIES-1:0] r_busy, n_busy;
    logic [23:0]       r_eaddr   [ENTRIES];
    logic [SEGMENTS-1:0] r_mask  [ENTRIES];
    logic [31:0]       r_seen    [ENTRIES];
    logic [EW-1:0]     r_sweep;
    logic [EW-1:0]     r_ent;
    logic              r_hit;
    logic              r_has_free;
    t_flush_job        r_job;

    // Associative match of the offered item and lowest free entry.
    logic [EW-1:0] w_hit_e, w_free_e;
    logic          w_hit, w_free;
    always_comb begin
        w_hit = 1'b0;
        w_hit_e = '0;
        w_free = 1'b0;
        w_free_e = '0;
        for (int e = ENTRIES - 1; e >= 0; e--) begin
            if (r_valid[e] && r_eaddr[e] == i_item.addr) begin
                w_hit = 1'b1;
                w_hit_e = EW'(e);
            end
            if (!r_valid[e]) begin
                w_free = 1'b1;
                w_free_e = EW'(e);
            end
        end
    end

    // Mask after this segment and its contiguous run.
    logic [SEGMENTS-1:0] w_mask;
    logic [4:0]          w_run;
    logic                w_later;
    logic [31:0]         w_age;
    always_comb begin
        w_mask = (r_hit ? r_mask[r_ent] : '0)
               | (SEGMENTS'(1) << r_item.seg_index[SW-1:0]);
        w_run = 5'(SEGMENTS);
        for (int k = SEGMENTS - 1; k >= 0; k--) begin
            if (!w_mask[k]) begin
                w_run = 5'(k);
            end
        end
        w_later = 1'b0;
        for (int k = 0; k < SEGMENTS; k++) begin
            if (k >= w_run && w_mask[k]) begin
                w_later = 1'b1;
            end
        end
        w_age = r_item.time_ms - r_seen[r_sweep];
    end

    // Tick run length of the swept entry.
    logic [4:0] w_trun;
    always_comb begin
        w_trun = 5'(SEGMENTS);
        for (int k = SEGMENTS - 1; k >= 0; k--) begin
            if (!r_mask[r_sweep][k]) begin
                w_trun = 5'(k);
            end
        end
    end

    logic w_idx_ok;
    assign w_idx_ok = ({1'b0, r_item.seg_index} < 5'(SEGMENTS));

    // A new address may not take an entry whose run is still being streamed.
    logic w_wait;
    assign w_wait = (r_state == S_EVAL) && (r_item.cmd == CMD_SEGMENT) && w_idx_ok
                    && !r_hit && r_has_free && r_busy[r_ent];

    assign o_ready     = (r_state == S_IDLE);
    assign o_job_valid = (r_state == S_FLUSH);
    assign o_job       = r_job;

    always_comb begin
        o_st_we    = 1'b0;
        o_st_waddr = {r_ent, r_item.seg_index[SW-1:0]};
        o_st_wdata = {r_item.data_high, r_item.data_low};
        if (r_state == S_EVAL && r_item.cmd == CMD_SEGMENT && w_idx_ok
            && (r_hit || r_has_free) && !w_wait) begin
            o_st_we = 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_valid) n_state = S_EVAL;
            S_EVAL:  n_state = w_wait ? S_EVAL : S_IDLE;
            S_FLUSH: if (i_job_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
        if (r_state == S_EVAL) begin
            if (r_item.cmd == CMD_TICK) begin
                if (r_valid[r_sweep] && w_age > i_ttl_ms && r_mask[r_sweep][0]) begin
                    n_state = S_FLUSH;
                end
            end else if (w_idx_ok && (r_hit || r_has_free) && !w_wait && w_mask[0]
                         && (r_item.close_out || w_run == 5'(SEGMENTS)
                             || (w_run >= 5'd2 && w_later))) begin
                n_state = S_FLUSH;
            end
        end
    end

    // Entries are busy from the hand-off of their flush job until the run has left.
    always_comb begin
        n_busy = r_busy;
        if (i_done) begin
            n_busy[i_done_entry] = 1'b0;
        end
        if (r_state == S_FLUSH && i_job_ready) begin
            n_busy[r_job.entry[EW-1:0]] = 1'b1;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_busy  <= '0;
            r_sweep <= '0;
            for (int e = 0; e < ENTRIES; e++) begin
                r_mask[e] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
            if (r_state == S_EVAL) begin
                if (r_item.cmd == CMD_TICK) begin
                    r_sweep <= (r_sweep == EW'(ENTRIES - 1)) ? '0 : r_sweep + 1'b1;
                    if (r_valid[r_sweep] && w_age > i_ttl_ms) begin
                        r_valid[r_sweep] <= 1'b0;
                        r_mask[r_sweep]  <= '0;
                    end
                end else if (w_idx_ok && (r_hit || r_has_free) && !w_wait) begin
                    if (n_state == S_FLUSH) begin
                        r_valid[r_ent] <= 1'b0;
                        r_mask[r_ent]  <= '0;
                    end else begin
                        r_valid[r_ent] <= 1'b1;
                        r_mask[r_ent]  <= w_mask;
                    end
                end
            end
        end
    end

    // Item capture, lookup results, entry payload and job.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_item <= i_item;
        end
        if (r_state == S_IDLE) begin
            r_hit      <= w_hit;
            r_has_free <= w_free;
            r_ent      <= w_hit ? w_hit_e : w_free_e;
        end
        if (r_state == S_EVAL) begin
            if (r_item.cmd == CMD_TICK) begin
                r_job.addr  <= r_eaddr[r_sweep];
                r_job.entry <= 8'(r_sweep);
                r_job.count <= w_trun;
                r_job.cause <= CAUSE_EXPIRED;
            end else if (w_idx_ok && (r_hit || r_has_free) && !w_wait) begin
                r_eaddr[r_ent] <= r_item.addr;
                r_seen[r_ent]  <= r_item.time_ms;
                r_job.addr  <= r_item.addr;
                r_job.entry <= 8'(r_ent);
                r_job.count <= w_run;
                r_job.cause <= r_item.close_out ? CAUSE_CLOSE
                             : (w_run == 5'(SEGMENTS)) ? CAUSE_ALL : CAUSE_LATER;
            end
        end
    end
endmodule
`default_nettype wire

// ===== rtl/smr_queue.sv =====
`default_nettype none
module smr_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire smr_pkg::t_flush_job i_job,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output smr_pkg::t_flush_job      o_job
);
    import smr_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_flush_job     r_buf [DEPTH];
    logic [AW-1:0]  r_wp, r_rp;
    logic [AW:0]    r_cnt;
    logic           w_push, w_pop;

    assign o_ready = (r_cnt != (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_buf[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    // Small circular job queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(w_push) - (AW+1)'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wp] <= i_job;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/smr_back.sv =====
`default_nettype none
module smr_back #(
    parameter int EW = 4,
    parameter int SW = 4
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_job_valid,
    output logic                     o_job_ready,
    input  wire smr_pkg::t_flush_job i_job,
    output logic [EW+SW-1:0]         o_st_raddr,
    input  wire logic [79:0]         i_st_rdata,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic [23:0]              o_addr,
    output logic [3:0]               o_index,
    output logic [63:0]              o_data_low,
    output logic [15:0]              o_data_high,
    output logic [4:0]               o_count,
    output logic [1:0]               o_cause,
    output logic                     o_last,
    output logic                     o_done,
    output logic [EW-1:0]            o_done_entry
);
    import smr_pkg::*;

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_READ = 3'b010,
        B_OUT  = 3'b100
    } t_bstate;

    t_bstate    r_state;
    t_flush_job r_job;
    logic [4:0] r_k;

    assign o_job_ready = (r_state == B_IDLE);
    assign o_st_raddr  = {r_job.entry[EW-1:0], r_k[SW-1:0]};
    assign o_valid     = (r_state == B_OUT);
    assign o_addr      = r_job.addr;
    assign o_index     = r_k[3:0];
    assign o_data_low  = i_st_rdata[63:0];
    assign o_data_high = i_st_rdata[79:64];
    assign o_count     = r_job.count;
    assign o_cause     = r_job.cause;
    assign o_last      = (r_k + 5'd1 == r_job.count);

    // The entry's run has fully left once its final segment is taken.
    assign o_done       = (r_state == B_OUT) && i_ready && o_last;
    assign o_done_entry = r_job.entry[EW-1:0];

    // One store read per segment; the read data holds while stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_k     <= '0;
        end else begin
            case (r_state)
                B_IDLE: if (i_job_valid) begin
                    r_state <= B_READ;
                    r_k     <= '0;
                end
                B_READ: r_state <= B_OUT;
                B_OUT: if (i_ready) begin
                    if (o_last) begin
                        r_state <= B_IDLE;
                    end else begin
                        r_k     <= r_k + 5'd1;
                        r_state <= B_READ;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == B_IDLE && i_job_valid) begin
            r_job <= i_job;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/segmented_message_reassembler_core.sv =====
`default_nettype none
// Segment reassembler with a fully associative table of address entries.
// Input channel (i_valid/o_ready) takes segment arrivals and sweep ticks;
// the output channel (o_valid/i_ready) streams flushed runs, one segment
// per item, lowest index first, with o_last on the final one.
// The front end takes each item in a capture/lookup state and an update
// state, handing any flush job to the two-entry job queue in a flush state;
// it takes no new item until idle again. The back end reads the segment
// store once per result, in a RAM read state and then a present state, and
// reads the next segment only after the receiver takes the current one.
// When the receiver stalls, the back end holds its result and the queue
// fills; the front end then holds its flush job and takes no items.
// A segment that would reuse an entry whose run is still streaming waits.
// Reset clears the valid bits, masks, sweep pointer and the queue, and sets
// ttl_ms to 30000; the segment store holds no reset value and needs no pass.
// ttl_ms is written over the APB port at byte address 0.
module segmented_message_reassembler_core #(
    parameter int ENTRIES  = 16,
    parameter int SEGMENTS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_cmd,
    input  wire logic [23:0] i_addr,
    input  wire logic [3:0]  i_seg_index,
    input  wire logic        i_close_out,
    input  wire logic [63:0] i_seg_data_low,
    input  wire logic [15:0] i_seg_data_high,
    input  wire logic [31:0] i_time_ms,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [23:0]      o_out_addr,
    output logic [3:0]       o_out_index,
    output logic [63:0]      o_out_data_low,
    output logic [15:0]      o_out_data_high,
    output logic [4:0]       o_seg_count,
    output logic [1:0]       o_cause,
    output logic             o_last
);
    import smr_pkg::*;

    localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int SW = $clog2(SEGMENTS);

    logic [31:0] r_ttl_ms;

    // Configuration register.
    assign pready = 1'b1;
    assign prdata = (paddr == REG_TTL_MS) ? r_ttl_ms : 32'd0;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ttl_ms <= TTL_RESET;
        end else if (psel && penable && pwrite && paddr == REG_TTL_MS) begin
            r_ttl_ms <= pwdata;
        end
    end

    t_in_item w_item;
    assign w_item = '{cmd: i_cmd, addr: i_addr, seg_index: i_seg_index,
                      close_out: i_close_out, data_low: i_seg_data_low,
                      data_high: i_seg_data_high, time_ms: i_time_ms};

    logic              w_st_we;
    logic [EW+SW-1:0]  w_st_waddr, w_st_raddr;
    logic [79:0]       w_st_wdata, w_st_rdata;
    logic              w_fj_valid, w_fj_ready, w_bj_valid, w_bj_ready;
    t_flush_job        w_fj, w_bj;
    logic              w_done;
    logic [EW-1:0]     w_done_entry;

    smr_front #(.ENTRIES(ENTRIES), .SEGMENTS(SEGMENTS), .EW(EW), .SW(SW)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_item(w_item), .i_ttl_ms(r_ttl_ms),
        .o_st_we(w_st_we), .o_st_waddr(w_st_waddr), .o_st_wdata(w_st_wdata),
        .o_job_valid(w_fj_valid), .i_job_ready(w_fj_ready), .o_job(w_fj),
        .i_done(w_done), .i_done_entry(w_done_entry)
    );

    smr_queue #(.DEPTH(2)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_fj_valid), .o_ready(w_fj_ready),
        .i_job(w_fj), .o_valid(w_bj_valid), .i_ready(w_bj_ready), .o_job(w_bj)
    );

    smr_ram #(.WIDTH(80), .DEPTH(ENTRIES * (2 ** SW))) u_store (
        .i_clk(i_clk), .i_we(w_st_we), .i_waddr(w_st_waddr), .i_wdata(w_st_wdata),
        .i_raddr(w_st_raddr), .o_rdata(w_st_rdata)
    );

    smr_back #(.EW(EW), .SW(SW)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_job_valid(w_bj_valid),
        .o_job_ready(w_bj_ready), .i_job(w_bj), .o_st_raddr(w_st_raddr),
        .i_st_rdata(w_st_rdata), .o_valid(o_valid), .i_ready(i_ready),
        .o_addr(o_out_addr), .o_index(o_out_index), .o_data_low(o_out_data_low),
        .o_data_high(o_out_data_high), .o_count(o_seg_count), .o_cause(o_cause),
        .o_last(o_last), .o_done(w_done), .o_done_entry(w_done_entry)
    );
endmodule
`default_nettype wire

// ===== verif/segmented_message_reassembler_core_tb.sv =====
`default_nettype none
module segmented_message_reassembler_core_tb;
    import smr_pkg::*;

    localparam int NUM_ENTRIES  = 16;
    localparam int NUM_SEGS     = 16;
    localparam int IDLE_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 80;

    // One flushed segment as it leaves the block.
    typedef struct packed {
        logic [23:0] addr;
        logic [3:0]  index;
        logic [63:0] data_low;
        logic [15:0] data_high;
        logic [4:0]  count;
        logic [1:0]  cause;
        logic        last;
    } t_flushed_seg;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_cmd = CMD_SEGMENT;
    logic [23:0] i_addr = '0;
    logic [3:0]  i_seg_index = '0;
    logic        i_close_out = 1'b0;
    logic [63:0] i_seg_data_low = '0;
    logic [15:0] i_seg_data_high = '0;
    logic [31:0] i_time_ms = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [23:0] o_out_addr;
    logic [3:0]  o_out_index;
    logic [63:0] o_out_data_low;
    logic [15:0] o_out_data_high;
    logic [4:0]  o_seg_count;
    logic [1:0]  o_cause;
    logic        o_last;

    segmented_message_reassembler_core dut (.*);

    // Clock with a period of 10.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the reassembly table.
    logic [31:0] ttl_shadow;
    bit          tbl_valid [NUM_ENTRIES];
    logic [23:0] tbl_addr [NUM_ENTRIES];
    logic [15:0] tbl_mask [NUM_ENTRIES];
    logic [31:0] tbl_seen [NUM_ENTRIES];
    logic [63:0] seg_low [NUM_ENTRIES][NUM_SEGS];
    logic [15:0] seg_high [NUM_ENTRIES][NUM_SEGS];
    int          sweep_pos;

    t_flushed_seg pending_segs[$];
    int errors = 0;
    int sent_items = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_recv = 1'b0;
    logic [31:0] now_ms = '0;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic int run_length(input logic [15:0] mask);
        int n;
        n = 0;
        while (n < NUM_SEGS && mask[n]) n++;
        return n;
    endfunction

    // Queue the contiguous run of an entry and free it.
    function automatic void flush_entry(input int e, input logic [1:0] cause);
        int n;
        t_flushed_seg s;
        n = run_length(tbl_mask[e]);
        for (int k = 0; k < n; k++) begin
            s.addr = tbl_addr[e];
            s.index = 4'(k);
            s.data_low = seg_low[e][k];
            s.data_high = seg_high[e][k];
            s.count = 5'(n);
            s.cause = cause;
            s.last = (k == n - 1);
            pending_segs.push_back(s);
        end
        tbl_valid[e] = 1'b0;
        tbl_mask[e] = '0;
    endfunction

    // Work out what one accepted item causes.
    function automatic void predict_item(input logic cmd, input logic [23:0] addr,
                                         input logic [3:0] idx, input logic close,
                                         input logic [63:0] lo, input logic [15:0] hi,
                                         input logic [31:0] t);
        int e;
        int run;
        logic [15:0] mask;
        if (cmd == CMD_TICK) begin
            e = sweep_pos;
            sweep_pos = (sweep_pos + 1) % NUM_ENTRIES;
            if (tbl_valid[e] && (t - tbl_seen[e]) > ttl_shadow) begin
                if (tbl_mask[e][0]) begin
                    flush_entry(e, CAUSE_EXPIRED);
                end else begin
                    tbl_valid[e] = 1'b0;
                    tbl_mask[e] = '0;
                end
            end
            return;
        end
        e = -1;
        for (int i = 0; i < NUM_ENTRIES; i++)
            if (e < 0 && tbl_valid[i] && tbl_addr[i] == addr) e = i;
        if (e < 0) begin
            for (int i = 0; i < NUM_ENTRIES; i++)
                if (e < 0 && !tbl_valid[i]) e = i;
            if (e < 0) return;
            tbl_valid[e] = 1'b1;
            tbl_addr[e] = addr;
            tbl_mask[e] = '0;
        end
        seg_low[e][idx] = lo;
        seg_high[e][idx] = hi;
        tbl_mask[e][idx] = 1'b1;
        tbl_seen[e] = t;
        mask = tbl_mask[e];
        if (!mask[0]) return;
        run = run_length(mask);
        if (close) flush_entry(e, CAUSE_CLOSE);
        else if (run == NUM_SEGS) flush_entry(e, CAUSE_ALL);
        else if (run >= 2 && (mask >> run) != 0) flush_entry(e, CAUSE_LATER);
    endfunction

    // Offer one item and hold it until the block takes it.
    task automatic send_item(input logic cmd, input logic [23:0] addr, input logic [3:0] idx,
                             input logic close, input logic [63:0] lo, input logic [15:0] hi,
                             input logic [31:0] t);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd <= cmd;
        i_addr <= addr;
        i_seg_index <= idx;
        i_close_out <= close;
        i_seg_data_low <= lo;
        i_seg_data_high <= hi;
        i_time_ms <= t;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_item(cmd, addr, idx, close, lo, hi, t);
        sent_items++;
        @(negedge i_clk);
    endtask

    task automatic send_seg(input logic [23:0] addr, input int idx, input logic close);
        now_ms += $urandom_range(0, 40);
        send_item(CMD_SEGMENT, addr, 4'(idx), close, {$urandom, $urandom}, 16'($urandom),
                  now_ms);
    endtask

    task automatic send_tick(input logic [31:0] t);
        send_item(CMD_TICK, 24'($urandom), 4'($urandom), 1'($urandom),
                  {$urandom, $urandom}, 16'($urandom), t);
    endtask

    task automatic sweep_all(input logic [31:0] t);
        for (int i = 0; i < NUM_ENTRIES; i++) send_tick(t);
    endtask

    // Let the block drain before touching the register.
    task automatic wait_idle();
        i_valid <= 1'b0;
        wait (pending_segs.size() == 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_ttl(input logic [31:0] value);
        wait_idle();
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= REG_TTL_MS;
        pwdata <= value;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        ttl_shadow = value;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // One message: an in-order run with a chosen ending, or random segments.
    task automatic send_message(input logic [23:0] addr);
        int n;
        int mode;
        mode = $urandom_range(0, 4);
        n = ($urandom_range(0, 9) == 0) ? NUM_SEGS : $urandom_range(1, 5);
        case (mode)
            0: begin
                for (int k = 0; k < n; k++) send_seg(addr, k, k == n - 1);
            end
            1: begin
                for (int k = 0; k < NUM_SEGS; k++) send_seg(addr, k, 1'b0);
            end
            2: begin
                if (n < 2) n = 2;
                if (n > 14) n = 14;
                for (int k = 0; k < n; k++) send_seg(addr, k, 1'b0);
                send_seg(addr, $urandom_range(n + 1, NUM_SEGS - 1), 1'b0);
            end
            3: begin
                if (n > 15) n = 15;
                for (int k = 0; k < n; k++) send_seg(addr, k, 1'b0);
            end
            default: begin
                for (int k = 0; k < n; k++)
                    send_seg(addr, $urandom_range(0, NUM_SEGS - 1), $urandom_range(0, 4) == 0);
            end
        endcase
    endtask

    // Result checker.
    always @(posedge i_clk) begin
        t_flushed_seg got;
        t_flushed_seg want;
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_out_addr, o_out_index, o_out_data_low, o_out_data_high,
                    o_seg_count, o_cause, o_last};
            if (pending_segs.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", got));
            end else begin
                want = pending_segs.pop_front();
                if (got.addr !== want.addr)
                    report_mismatch($sformatf("addr %h want %h", got.addr, want.addr));
                if (got.index !== want.index)
                    report_mismatch($sformatf("index %h want %h", got.index, want.index));
                if (got.data_low !== want.data_low)
                    report_mismatch($sformatf("data_low %h want %h", got.data_low,
                                              want.data_low));
                if (got.data_high !== want.data_high)
                    report_mismatch($sformatf("data_high %h want %h", got.data_high,
                                              want.data_high));
                if (got.count !== want.count)
                    report_mismatch($sformatf("count %0d want %0d", got.count, want.count));
                if (got.cause !== want.cause)
                    report_mismatch($sformatf("cause %0d want %0d", got.cause, want.cause));
                if (got.last !== want.last)
                    report_mismatch($sformatf("last %b want %b", got.last, want.last));
            end
        end
    end

    // Receiver readiness.
    always @(negedge i_clk)
        i_ready <= hold_recv ? 1'b0 : ($urandom_range(0, 99) >= recv_stall_pct);

    // Watchdog on cycles with no handshake on either channel and no APB access.
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || psel) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic test_causes();
        // Single segment 0 with close-out at the extremes of address and data.
        now_ms = 32'd100;
        send_item(CMD_SEGMENT, 24'h000000, 4'd0, 1'b1, '0, '0, now_ms);
        send_item(CMD_SEGMENT, 24'hFFFFFF, 4'd0, 1'b1, '1, '1, now_ms);
        // All segments present.
        for (int k = 0; k < NUM_SEGS; k++) send_seg(24'h123456, k, 1'b0);
        // Run of two then a later segment, with an overwrite first.
        send_seg(24'hABCDEF, 0, 1'b0);
        send_seg(24'hABCDEF, 0, 1'b0);
        send_seg(24'hABCDEF, 1, 1'b0);
        send_seg(24'hABCDEF, 15, 1'b0);
        // Close-out before segment 0 waits for it.
        send_seg(24'h00F00F, 2, 1'b1);
        send_seg(24'h00F00F, 0, 1'b1);
    endtask

    task automatic test_table_full();
        for (int i = 0; i < NUM_ENTRIES + 1; i++) send_seg(24'h100 + i, 1, 1'b0);
        send_seg(24'h100, 0, 1'b1);
        send_seg(24'h100 + NUM_ENTRIES, 0, 1'b1);
    endtask

    task automatic test_expiry();
        // Age equal to the reset TTL does not expire; one more does.
        // The sweep pointer starts at entry 0, which holds this message.
        send_seg(24'h0A0A0A, 0, 1'b0);
        send_seg(24'h0A0A0A, 1, 1'b0);
        send_tick(now_ms + 32'd30000);
        sweep_all(now_ms + 32'd30001);
        now_ms += 32'd30001;
        write_ttl(32'd0);
        send_seg(24'h0B0B0B, 0, 1'b0);
        sweep_all(now_ms);
        sweep_all(now_ms + 1);
        write_ttl(32'hFFFFFFFF);
        now_ms = 32'hFFFFFFF0;
        send_item(CMD_SEGMENT, 24'h0C0C0C, 4'd0, 1'b0, '1, '0, now_ms);
        sweep_all(32'h00000005);
        write_ttl(32'd1);
        sweep_all(32'h00000010);
        now_ms = 32'h20;
    endtask

    task automatic test_random(input int items);
        int start;
        logic [23:0] pool [6];
        for (int i = 0; i < 6; i++) pool[i] = 24'($urandom);
        start = sent_items;
        while (sent_items - start < items) begin
            if ($urandom_range(0, 4) != 0) begin
                send_message(pool[$urandom_range(0, 5)]);
            end else if ($urandom_range(0, 1) == 0) begin
                now_ms += $urandom_range(0, 3000);
                for (int i = $urandom_range(1, 16); i > 0; i--) send_tick(now_ms);
            end else begin
                send_item(1'($urandom), 24'($urandom), 4'($urandom), 1'($urandom),
                          {$urandom, $urandom}, 16'($urandom), $urandom);
            end
        end
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_recv = 1'b1;
                repeat (400) @(negedge i_clk);
                hold_recv = 1'b0;
            end
        join_none
        for (int m = 0; m < 3; m++)
            for (int k = 0; k < 8; k++) send_seg(24'h300 + m, k, k == 7);
    endtask

    initial begin
        ttl_shadow = TTL_RESET;
        sweep_pos = 0;
        for (int e = 0; e < NUM_ENTRIES; e++) begin
            tbl_valid[e] = 1'b0;
            tbl_mask[e] = '0;
        end
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_causes();
        test_table_full();
        test_expiry();

        write_ttl(32'd500);
        send_idle_pct = 0;  recv_stall_pct = 0;  test_random(6);
        write_ttl($urandom_range(100, 3000));
        send_idle_pct = 50; recv_stall_pct = 0;  test_random(6);
        write_ttl($urandom_range(100, 3000));
        send_idle_pct = 0;  recv_stall_pct = 50; test_random(6);
        write_ttl($urandom_range(100, 3000));
        send_idle_pct = 7;  recv_stall_pct = 7;  test_random(6);
        send_idle_pct = 0;  recv_stall_pct = 0;
        test_backpressure();

        i_valid <= 1'b0;
        wait (pending_segs.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_segs.size() != 0) report_mismatch("results still expected at end");
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== files.f =====
rtl/smr_pkg.sv
rtl/smr_ram.sv
rtl/smr_front.sv
rtl/smr_queue.sv
rtl/smr_back.sv
rtl/segmented_message_reassembler_core.sv
verif/segmented_message_reassembler_core_tb.sv
